>>> rtl/core/source_char_canonicalizer_top_defines.svh
// Assertion helpers for the source character canonicalizer.
`ifndef SOURCE_CHAR_CANONICALIZER_TOP_DEFINES_SVH
`define SOURCE_CHAR_CANONICALIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scc check failed");

// Next-cycle implication.
`define SCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scc check failed");

`else

`define SCC_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define SCC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/scc_pkg.sv
package scc_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int OUT_POS_BITS          = 16;
   localparam int MAX_RESULTS           = 2;
   localparam int CNT_BITS              = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_BS = 8'h5C;

   typedef struct packed {
      logic bs_pend;
      logic after_cr;
      logic last_nl;
   } flags_type;

   typedef struct packed {
      logic [7:0]              char_out;
      logic                    is_end;
      logic [OUT_POS_BITS-1:0] line_number;
      logic [OUT_POS_BITS-1:0] column_number;
      logic                    last_of_run;
   } result_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] cnt;
      result_type          r0;
      result_type          r1;
   } step_res_type;

   function automatic result_type mk_res(input logic [7:0] ch, input logic is_end,
                                         input logic [OUT_POS_BITS-1:0] line,
                                         input logic [OUT_POS_BITS-1:0] col,
                                         input logic last);
      result_type r;
      r.char_out      = ch;
      r.is_end        = is_end;
      r.line_number   = line;
      r.column_number = col;
      r.last_of_run   = last;
      return r;
   endfunction

endpackage

>>> rtl/core/scc_step.sv
module scc_step #(
   parameter int POSITION_BITS = scc_pkg::POSITION_BITS_DEFAULT
) (
   input  logic [7:0]               byte_in,
   input  logic                     end_in,
   input  scc_pkg::flags_type       flags,
   input  logic [POSITION_BITS-1:0] line_cnt,
   input  logic [POSITION_BITS-1:0] col_cnt,
   output scc_pkg::step_res_type    res,
   output scc_pkg::flags_type       flags_next,
   output logic [POSITION_BITS-1:0] line_next,
   output logic [POSITION_BITS-1:0] col_next
);

   localparam int EXT_BITS = (POSITION_BITS > scc_pkg::OUT_POS_BITS) ?
                             POSITION_BITS : scc_pkg::OUT_POS_BITS;

   logic [7:0]               ch;
   logic                     ch_nl;
   logic                     ch_bs;
   logic [POSITION_BITS-1:0] line_c;
   logic [POSITION_BITS-1:0] col_c;
   logic [EXT_BITS-1:0]      line_old_x;
   logic [EXT_BITS-1:0]      col_old_x;
   logic [EXT_BITS-1:0]      line_new_x;
   logic [EXT_BITS-1:0]      col_new_x;
   logic [scc_pkg::OUT_POS_BITS-1:0] line_old;
   logic [scc_pkg::OUT_POS_BITS-1:0] col_old;
   logic [scc_pkg::OUT_POS_BITS-1:0] line_new;
   logic [scc_pkg::OUT_POS_BITS-1:0] col_new;

   // end marker inserts a newline, CR is canonicalized to newline
   assign ch    = (end_in || byte_in == scc_pkg::CH_CR) ? scc_pkg::CH_NL : byte_in;
   assign ch_nl = (ch == scc_pkg::CH_NL);
   assign ch_bs = (ch == scc_pkg::CH_BS);

   // counters after consuming ch, saturating
   assign line_c = !ch_nl ? line_cnt :
                   (&line_cnt) ? line_cnt : line_cnt + POSITION_BITS'(1);
   assign col_c  = ch_nl ? '0 :
                   (&col_cnt) ? col_cnt : col_cnt + POSITION_BITS'(1);

   assign line_old_x = EXT_BITS'(line_cnt);
   assign col_old_x  = EXT_BITS'(col_cnt);
   assign line_new_x = EXT_BITS'(line_c);
   assign col_new_x  = EXT_BITS'(col_c);
   assign line_old   = line_old_x[scc_pkg::OUT_POS_BITS-1:0];
   assign col_old    = col_old_x[scc_pkg::OUT_POS_BITS-1:0];
   assign line_new   = line_new_x[scc_pkg::OUT_POS_BITS-1:0];
   assign col_new    = col_new_x[scc_pkg::OUT_POS_BITS-1:0];

   always_comb begin
      res        = '0;
      flags_next = flags;
      line_next  = line_cnt;
      col_next   = col_cnt;
      if (end_in) begin
         flags_next = '0;
         line_next  = POSITION_BITS'(1);
         col_next   = '0;
         if (flags.last_nl) begin
            res.cnt = scc_pkg::CNT_BITS'(1);
            res.r0  = scc_pkg::mk_res('0, 1'b1, line_old, col_old, 1'b1);
         end else if (flags.bs_pend) begin
            // trailing backslash splices with the inserted newline
            res.cnt = scc_pkg::CNT_BITS'(1);
            res.r0  = scc_pkg::mk_res('0, 1'b1, line_new, col_new, 1'b1);
         end else begin
            res.cnt = scc_pkg::CNT_BITS'(2);
            res.r0  = scc_pkg::mk_res(scc_pkg::CH_NL, 1'b0, line_new, col_new, 1'b0);
            res.r1  = scc_pkg::mk_res('0, 1'b1, line_new, col_new, 1'b1);
         end
      end else if (flags.after_cr && byte_in == scc_pkg::CH_NL) begin
         // LF of a CR LF pair is dropped
         flags_next.after_cr = 1'b0;
      end else begin
         flags_next.after_cr = (byte_in == scc_pkg::CH_CR);
         flags_next.last_nl  = ch_nl;
         line_next           = line_c;
         col_next            = col_c;
         if (flags.bs_pend) begin
            if (ch_nl) begin
               flags_next.bs_pend = 1'b0;
            end else begin
               res.r0 = scc_pkg::mk_res(scc_pkg::CH_BS, 1'b0, line_old, col_old, ch_bs);
               if (ch_bs) begin
                  res.cnt = scc_pkg::CNT_BITS'(1);
               end else begin
                  res.cnt            = scc_pkg::CNT_BITS'(2);
                  res.r1             = scc_pkg::mk_res(ch, 1'b0, line_new, col_new, 1'b1);
                  flags_next.bs_pend = 1'b0;
               end
            end
         end else if (ch_bs) begin
            flags_next.bs_pend = 1'b1;
         end else begin
            res.cnt = scc_pkg::CNT_BITS'(1);
            res.r0  = scc_pkg::mk_res(ch, 1'b0, line_new, col_new, 1'b1);
         end
      end
   end

endmodule

>>> rtl/core/scc_rsp_buf.sv
module scc_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  scc_pkg::step_res_type load_res,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output scc_pkg::result_type   rsp_res
);

   logic [scc_pkg::CNT_BITS-1:0] cnt_ff;
   logic [scc_pkg::CNT_BITS-1:0] cnt_in;
   logic                         pos_ff;
   logic                         pos_in;
   scc_pkg::result_type          r0_ff;
   scc_pkg::result_type          r0_in;
   scc_pkg::result_type          r1_ff;
   scc_pkg::result_type          r1_in;
   logic                         rsp_accept;

   assign rsp_valid  = (cnt_ff != '0);
   assign rsp_res    = pos_ff ? r1_ff : r0_ff;
   assign rsp_accept = rsp_valid && !rsp_stall;
   // room for a new request once the last held result leaves
   assign free       = (cnt_ff == '0) ||
                       (cnt_ff == scc_pkg::CNT_BITS'(1) && rsp_accept);

   always_comb begin
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      r0_in  = r0_ff;
      r1_in  = r1_ff;
      if (load) begin
         cnt_in = load_res.cnt;
         pos_in = 1'b0;
         r0_in  = load_res.r0;
         r1_in  = load_res.r1;
      end else if (rsp_accept) begin
         cnt_in = cnt_ff - scc_pkg::CNT_BITS'(1);
         pos_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
      r0_ff <= r0_in;
      r1_ff <= r1_in;
   end

endmodule

>>> rtl/core/source_char_canonicalizer_top.sv
// Channel   Dir  Signals                                         Accepted when
// req       in   req_valid req_stall req_byte_in req_end_of_input  valid && !stall
// rsp       out  rsp_valid rsp_stall rsp_char_out rsp_is_end ...   valid && !stall
//
// One request enters per cycle while req_stall is low; it is decoded from the input register
// into the result register once that register is free, and its first result is presented there.
// A request yields zero, one or two results; after a two-result request the next
// request waits in the input register while the result register drains.
// Synchronous active-high reset clears flags, sets line to 1 and column to 0.
// rsp_stall backs up into req_stall once the result register and input register are full.
`include "source_char_canonicalizer_top_defines.svh"

module source_char_canonicalizer_top #(
   parameter int POSITION_BITS = scc_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_byte_in,
   input  logic                             req_end_of_input,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_char_out,
   output logic                             rsp_is_end,
   output logic [scc_pkg::OUT_POS_BITS-1:0] rsp_line_number,
   output logic [scc_pkg::OUT_POS_BITS-1:0] rsp_column_number,
   output logic                             rsp_last_of_run
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     in_end_ff;
   scc_pkg::flags_type       flags_ff;
   scc_pkg::flags_type       flags_in;
   logic [POSITION_BITS-1:0] line_ff;
   logic [POSITION_BITS-1:0] line_in;
   logic [POSITION_BITS-1:0] col_ff;
   logic [POSITION_BITS-1:0] col_in;
   scc_pkg::step_res_type    step_res;
   scc_pkg::flags_type       step_flags;
   logic [POSITION_BITS-1:0] step_line;
   logic [POSITION_BITS-1:0] step_col;
   scc_pkg::result_type      rsp_res;
   logic                     buf_free;
   logic                     advance;
   logic                     req_accept;

   assign advance    = in_valid_ff && buf_free;
   assign req_stall  = in_valid_ff && !buf_free;
   assign req_accept = req_valid && !req_stall;

   scc_step #(.POSITION_BITS(POSITION_BITS)) u_step (
      .byte_in    (in_byte_ff),
      .end_in     (in_end_ff),
      .flags      (flags_ff),
      .line_cnt   (line_ff),
      .col_cnt    (col_ff),
      .res        (step_res),
      .flags_next (step_flags),
      .line_next  (step_line),
      .col_next   (step_col)
   );

   scc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_res  (step_res),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_char_out      = rsp_res.char_out;
   assign rsp_is_end        = rsp_res.is_end;
   assign rsp_line_number   = rsp_res.line_number;
   assign rsp_column_number = rsp_res.column_number;
   assign rsp_last_of_run   = rsp_res.last_of_run;

   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign flags_in    = advance ? step_flags : flags_ff;
   assign line_in     = advance ? step_line : line_ff;
   assign col_in      = advance ? step_col : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         flags_ff    <= '0;
         line_ff     <= POSITION_BITS'(1);
         col_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         flags_ff    <= flags_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
      end
      if (req_accept) begin
         in_byte_ff <= req_byte_in;
         in_end_ff  <= req_end_of_input;
      end
   end

   `SCC_ASSERT_IMPLY(a_end_is_last, clock, reset, rsp_valid && rsp_is_end, rsp_last_of_run)
   `SCC_ASSERT_NEXT(a_nonlast_followed, clock, reset, rsp_valid && !rsp_last_of_run, rsp_valid)
   `SCC_ASSERT_NEXT(a_end_resets_state, clock, reset, advance && in_end_ff,
      (flags_ff == '0) && (line_ff == POSITION_BITS'(1)) && (col_ff == '0))

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int RANDOM_REQS = 1750;
   localparam int LONG_HOLD   = 400;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0]          b;
      logic                e;
      logic                typed;
      logic [1:0]          n;
      scc_pkg::result_type x0;
      scc_pkg::result_type x1;
   } stim_row_type;

   localparam scc_pkg::result_type NO_RES = '0;
   localparam int N_DIRECTED = 24;

   // typed rows carry the expected results, the rest go through the predictor
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{8'h00, 1'b1, 1'b1, 2'd2, '{scc_pkg::CH_NL, 1'b0, 16'd2, 16'd0, 1'b0},
                                 '{8'h00, 1'b1, 16'd2, 16'd0, 1'b1}}, // empty stream
      '{8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b0, 16'd1, 16'd1, 1'b1}, NO_RES},
      '{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b0, 16'd1, 16'd2, 1'b1}, NO_RES},
      '{scc_pkg::CH_CR, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{scc_pkg::CH_NL, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},   // LF of CR LF dropped
      '{scc_pkg::CH_CR, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{scc_pkg::CH_CR, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},   // lone CR twice
      '{scc_pkg::CH_BS, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{scc_pkg::CH_NL, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},   // splice
      '{scc_pkg::CH_BS, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h78, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},   // held backslash released
      '{scc_pkg::CH_BS, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{scc_pkg::CH_BS, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{scc_pkg::CH_CR, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},   // splice on CR
      '{scc_pkg::CH_NL, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{scc_pkg::CH_BS, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},   // trailing backslash
      '{8'h71, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{scc_pkg::CH_NL, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'hFF, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},   // already at newline
      '{8'h7A, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},   // newline inserted
      '{scc_pkg::CH_CR, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'hA5, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES}
   };

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [7:0]  req_byte_in      = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_stall        = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_char_out;
   logic        rsp_is_end;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   logic        rsp_last_of_run;

   source_char_canonicalizer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_out     (rsp_char_out),
      .rsp_is_end       (rsp_is_end),
      .rsp_line_number  (rsp_line_number),
      .rsp_column_number(rsp_column_number),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic        bs_held;
   logic        cr_seen;
   logic        nl_last;
   logic [15:0] cur_line;
   logic [15:0] cur_col;

   scc_pkg::result_type expected_chars[$];
   int          error_count = 0;
   int          reqs_sent   = 0;
   int          burst_left  = 0;
   int          holds_asked = 0;
   int          holds_done  = 0;

   function automatic void canon_clear();
      bs_held  = 1'b0;
      cr_seen  = 1'b0;
      nl_last  = 1'b0;
      cur_line = 16'd1;
      cur_col  = 16'd0;
   endfunction

   function automatic void advance_pos(input logic [7:0] c);
      if (c == scc_pkg::CH_NL) begin
         if (cur_line != '1) cur_line = cur_line + 16'd1;
         cur_col = 16'd0;
      end else if (cur_col != '1) begin
         cur_col = cur_col + 16'd1;
      end
      nl_last = (c == scc_pkg::CH_NL);
   endfunction

   function automatic void add_char(inout scc_pkg::step_res_type s, input logic [7:0] c,
                                    input logic is_end);
      scc_pkg::result_type r;
      r.char_out      = c;
      r.is_end        = is_end;
      r.line_number   = cur_line;
      r.column_number = cur_col;
      r.last_of_run   = 1'b0;
      if (s.cnt == 0) s.r0 = r;
      else s.r1 = r;
      s.cnt = s.cnt + 1'b1;
   endfunction

   function automatic void feed_char(inout scc_pkg::step_res_type s, input logic [7:0] c);
      if (bs_held) begin
         bs_held = 1'b0;
         if (c == scc_pkg::CH_NL) begin
            advance_pos(c);
            return;
         end
         add_char(s, scc_pkg::CH_BS, 1'b0);
      end
      advance_pos(c);
      if (c == scc_pkg::CH_BS) bs_held = 1'b1;
      else add_char(s, c, 1'b0);
   endfunction

   function automatic scc_pkg::step_res_type canon_predict(input logic [7:0] b,
                                                           input logic e);
      scc_pkg::step_res_type s;
      s = '0;
      if (e) begin
         if (!nl_last) feed_char(s, scc_pkg::CH_NL);
         add_char(s, 8'h00, 1'b1);
         canon_clear();
      end else if (cr_seen && b == scc_pkg::CH_NL) begin
         cr_seen = 1'b0;
      end else begin
         cr_seen = (b == scc_pkg::CH_CR);
         feed_char(s, (b == scc_pkg::CH_CR) ? scc_pkg::CH_NL : b);
      end
      if (s.cnt == 2) s.r1.last_of_run = 1'b1;
      else if (s.cnt == 1) s.r0.last_of_run = 1'b1;
      return s;
   endfunction

   function automatic logic [7:0] pick_byte(input bit plain);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (plain || sel >= 50) return 8'($urandom_range(0, 255));
      if (sel < 20) return scc_pkg::CH_NL;
      if (sel < 32) return scc_pkg::CH_CR;
      if (sel < 45) return scc_pkg::CH_BS;
      return 8'(8'h20 + $urandom_range(0, 94));
   endfunction

   task automatic send_request(input stim_row_type row);
      scc_pkg::step_res_type got;
      int unsigned           gap;
      req_valid        <= 1'b1;
      req_byte_in      <= row.b;
      req_end_of_input <= row.e;
      do @(posedge clock); while (req_stall);
      got = canon_predict(row.b, row.e);
      if (row.typed) begin
         got.cnt = row.n;
         got.r0  = row.x0;
         got.r1  = row.x1;
      end
      if (got.cnt > 0) expected_chars.push_back(got.r0);
      if (got.cnt > 1) expected_chars.push_back(got.r1);
      reqs_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic e);
      stim_row_type row;
      row       = '0;
      row.b     = b;
      row.e     = e;
      send_request(row);
   endtask

   // response checker
   always @(posedge clock) begin
      scc_pkg::result_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("tb: unexpected rsp c=%h end=%b line=%0d col=%0d last=%b",
                        rsp_char_out, rsp_is_end, rsp_line_number,
                        rsp_column_number, rsp_last_of_run);
            error_count++;
         end else begin
            x = expected_chars.pop_front();
            if (rsp_char_out !== x.char_out || rsp_is_end !== x.is_end ||
                rsp_line_number !== x.line_number ||
                rsp_column_number !== x.column_number ||
                rsp_last_of_run !== x.last_of_run) begin
               if (error_count < MAX_REPORTS) begin
                  $write("tb: mismatch exp c=%h end=%b line=%0d col=%0d last=%b",
                         x.char_out, x.is_end, x.line_number, x.column_number,
                         x.last_of_run);
                  $display(" got c=%h end=%b line=%0d col=%0d last=%b",
                           rsp_char_out, rsp_is_end, rsp_line_number,
                           rsp_column_number, rsp_last_of_run);
               end
               error_count++;
            end
         end
      end
   end

   // receiver stall patterns, plus long hold-offs on request
   initial begin
      int unsigned mode;
      int unsigned span;
      int unsigned period;
      int unsigned phase;
      forever begin
         mode   = $urandom_range(0, 3);
         span   = $urandom_range(10, 150);
         period = $urandom_range(2, 5);
         phase  = 0;
         repeat (span) begin
            @(posedge clock);
            if (holds_done != holds_asked) begin
               holds_done++;
               rsp_stall <= 1'b1;
               repeat (LONG_HOLD) @(posedge clock);
            end
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: begin
                  rsp_stall <= (phase == 0);
                  phase = (phase + 1) % period;
               end
            endcase
         end
      end
   end

   initial begin
      #30_000_000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      int unsigned len;
      bit          plain;

      canon_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) send_request(DIRECTED[i]);

      // random streams, mostly special-character heavy, each closed by an end marker
      holds_asked++;
      while (reqs_sent < N_DIRECTED + RANDOM_REQS) begin
         if (reqs_sent >= N_DIRECTED + RANDOM_REQS / 2 && holds_asked == 1) holds_asked++;
         len   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 60);
         plain = ($urandom_range(0, 4) == 0);
         repeat (len) send_byte(pick_byte(plain), 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end

      repeat (5) send_byte(pick_byte(1'b0), 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b1);

      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

>>> source_char_canonicalizer_top.f
+incdir+rtl/core
rtl/core/scc_pkg.sv
rtl/core/scc_step.sv
rtl/core/scc_rsp_buf.sv
rtl/core/source_char_canonicalizer_top.sv
test/tb.sv
